FILE: src/assert_macros.svh
// assertion macros used by the tokenizer back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define JST_ASSERT_HOLD(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// trigger in one cycle implies the consequence in the next
`define JST_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: src/jst_pkg.sv
// types, codes and lookup functions of the json stream tokenizer
package jst_pkg;

  localparam int MAX_NESTING_DEF = 32;
  localparam int CMP_W = 9;
  localparam int STEPS = 7;
  localparam int MAX_RES = 4;
  localparam logic [5:0] LIMIT_RESET = 6'd32;

  typedef enum logic [20:0] {
    ST_EATWS   = 21'h000001,
    ST_START   = 21'h000002,
    ST_FINISH  = 21'h000004,
    ST_NULL    = 21'h000008,
    ST_CSTART  = 21'h000010,
    ST_COMMENT = 21'h000020,
    ST_CEOL    = 21'h000040,
    ST_CEND    = 21'h000080,
    ST_STRING  = 21'h000100,
    ST_ESC     = 21'h000200,
    ST_UNI     = 21'h000400,
    ST_BOOL    = 21'h000800,
    ST_NUMBER  = 21'h001000,
    ST_ARRAY   = 21'h002000,
    ST_ADD     = 21'h004000,
    ST_ASEP    = 21'h008000,
    ST_FSTART  = 21'h010000,
    ST_FIELD   = 21'h020000,
    ST_FEND    = 21'h040000,
    ST_OVALUE  = 21'h080000,
    ST_OSEP    = 21'h100000
  } st_t;

  localparam logic [3:0] EV_OBJ_BEGIN = 4'd1;
  localparam logic [3:0] EV_OBJ_END   = 4'd2;
  localparam logic [3:0] EV_ARR_BEGIN = 4'd3;
  localparam logic [3:0] EV_ARR_END   = 4'd4;
  localparam logic [3:0] EV_KEY_BYTE  = 4'd5;
  localparam logic [3:0] EV_KEY_END   = 4'd6;
  localparam logic [3:0] EV_STR_BYTE  = 4'd7;
  localparam logic [3:0] EV_STR_END   = 4'd8;
  localparam logic [3:0] EV_NUM_BYTE  = 4'd9;
  localparam logic [3:0] EV_NUM_END   = 4'd10;
  localparam logic [3:0] EV_NULL      = 4'd11;
  localparam logic [3:0] EV_TRUE      = 4'd12;
  localparam logic [3:0] EV_FALSE     = 4'd13;
  localparam logic [3:0] EV_ERROR     = 4'd14;
  localparam logic [3:0] EV_DONE      = 4'd15;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_DEPTH    = 4'd1;
  localparam logic [3:0] ERR_EOF      = 4'd2;
  localparam logic [3:0] ERR_UNEXP    = 4'd3;
  localparam logic [3:0] ERR_NULL     = 4'd4;
  localparam logic [3:0] ERR_BOOL     = 4'd5;
  localparam logic [3:0] ERR_NUMBER   = 4'd6;
  localparam logic [3:0] ERR_ARR_SEP  = 4'd7;
  localparam logic [3:0] ERR_KEY      = 4'd8;
  localparam logic [3:0] ERR_KEY_SEP  = 4'd9;
  localparam logic [3:0] ERR_VAL_SEP  = 4'd10;
  localparam logic [3:0] ERR_STRING   = 4'd11;
  localparam logic [3:0] ERR_COMMENT  = 4'd12;

  localparam logic [1:0] LK_NONE  = 2'd0;
  localparam logic [1:0] LK_VALID = 2'd1;

  // classified text word as it sits in the queue
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] low;
    logic       ws;
    logic       digit;
    logic       numb;
    logic       hexok;
    logic [3:0] hexv;
    logic       eot;
  } q_item_t;

  typedef struct packed {
    logic [3:0] ev;
    logic [7:0] data;
    logic [5:0] lvl;
    logic [3:0] err;
    logic       dec;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] e;
    logic [2:0]         n;
  } bundle_t;

  function automatic res_t mkres(logic [3:0] ev, logic [7:0] data, logic [5:0] lvl,
                                 logic [3:0] err, logic dec);
    res_t r;
    r.ev = ev;
    r.data = data;
    r.lvl = lvl;
    r.err = err;
    r.dec = dec;
    return r;
  endfunction

  function automatic bundle_t push_ev(bundle_t b, res_t x);
    bundle_t o;
    o = b;
    if (o.n < 3'(MAX_RES)) begin
      o.e[o.n[1:0]] = x;
      o.n = o.n + 3'd1;
    end
    return o;
  endfunction

  function automatic logic [7:0] null_ch(logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = "n";
      2'd1: c = "u";
      default: c = "l";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] true_ch(logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = "t";
      2'd1: c = "r";
      2'd2: c = "u";
      default: c = "e";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] false_ch(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "f";
      3'd1: c = "a";
      3'd2: c = "l";
      3'd3: c = "s";
      default: c = "e";
    endcase
    return c;
  endfunction

endpackage

FILE: src/jst_in_if.sv
// text word channel into the tokenizer
interface jst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

FILE: src/jst_out_if.sv
// token word channel out of the tokenizer
interface jst_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [7:0] data_byte;
  logic [5:0] nesting_level;
  logic [3:0] error_code;
  logic       number_is_decimal;
  logic       last_of_run;

  modport source(output valid, output event_res, output data_byte, output nesting_level,
                 output error_code, output number_is_decimal, output last_of_run,
                 input ready);
  modport sink(input valid, input event_res, input data_byte, input nesting_level,
               input error_code, input number_is_decimal, input last_of_run,
               output ready);
endinterface

FILE: src/jst_front.sv
// front end: takes text words and classifies each byte
module jst_front (
  jst_in_if.sink          byte_in,
  output logic            item_valid,
  output jst_pkg::q_item_t item,
  input  logic            item_ready
);

  logic [7:0] b;
  logic       up;

  assign b = byte_in.text_byte;
  assign up = (b >= "A") && (b <= "Z");

  assign byte_in.ready = item_ready;
  assign item_valid = byte_in.valid;

  always_comb begin
    item.raw = b;
    item.low = up ? b + 8'd32 : b;
    item.ws = (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    item.digit = (b >= "0") && (b <= "9");
    item.numb = item.digit || (b == ".") || (b == "+") || (b == "-") ||
                (b == "e") || (b == "E");
    item.hexok = item.digit || ((item.low >= "a") && (item.low <= "f"));
    item.hexv = item.digit ? 4'(b - "0") : 4'(item.low - "a" + 8'd10);
    item.eot = byte_in.end_of_text;
  end

endmodule

FILE: src/jst_queue.sv
// two-entry queue between front and back
module jst_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  jst_pkg::q_item_t wr_item,
  output logic             wr_ready,
  output logic             rd_valid,
  output jst_pkg::q_item_t rd_item,
  input  logic             rd_pop
);

  jst_pkg::q_item_t slot [2];
  logic [1:0] cnt;
  logic       push;
  logic       widx;

  assign wr_ready = (cnt != 2'd2);
  assign push = wr_valid && wr_ready;
  assign rd_valid = (cnt != 2'd0);
  assign rd_item = slot[0];
  // slot that takes the new word once a pop in the same cycle is counted
  assign widx = cnt[0] ^ rd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, rd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !widx) begin
      slot[0] <= wr_item;
    end else if (rd_pop) begin
      slot[0] <= slot[1];
    end
    if (push && widx) begin
      slot[1] <= wr_item;
    end
  end

endmodule

FILE: src/jst_back.sv
// back end: per-level token state machine, nesting stack and result register
`include "assert_macros.svh"

module jst_back #(
  parameter int MAX_NESTING = jst_pkg::MAX_NESTING_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [5:0]       limit,
  input  logic             q_valid,
  input  jst_pkg::q_item_t q_item,
  output logic             q_pop,
  jst_out_if.source        token_out
);

  localparam int DW = $clog2(MAX_NESTING);
  localparam int CW = jst_pkg::CMP_W;

  jst_pkg::st_t st, ret;
  logic                   kind;
  logic [DW-1:0]          depth;
  logic [MAX_NESTING-1:0] stk;
  logic [7:0]             quote;
  logic [2:0]             lpos;
  logic [1:0]             lkind;
  logic [15:0]            uacc;
  logic                   dec;
  logic [3:0]             err;

  jst_pkg::res_t [3:0] bq;
  logic [2:0]          rem;

  jst_pkg::st_t st_next, ret_next;
  logic          kind_next;
  logic [DW-1:0] depth_next;
  logic [7:0]    quote_next;
  logic [2:0]    lpos_next;
  logic [1:0]    lkind_next;
  logic [15:0]   uacc_next;
  logic          dec_next;
  logic [3:0]    err_next;
  jst_pkg::bundle_t bl;
  logic          popf, pushf, pk, clr;
  logic [CW-1:0] lim;
  logic          take, fire;

  assign fire = token_out.valid && token_out.ready;
  assign take = q_valid && ((rem == 3'd0) || ((rem == 3'd1) && token_out.ready));
  assign q_pop = take;

  always_comb begin
    if (limit == 6'd0) begin
      lim = CW'(1);
    end else if (CW'(limit) > CW'(MAX_NESTING)) begin
      lim = CW'(MAX_NESTING);
    end else begin
      lim = CW'(limit);
    end
  end

  always_comb begin
    logic       used, stop, key;
    logic [7:0] rb, lb, o;
    logic [15:0] u;
    logic       ook;
    st_next = st;
    ret_next = ret;
    kind_next = kind;
    depth_next = depth;
    quote_next = quote;
    lpos_next = lpos;
    lkind_next = lkind;
    uacc_next = uacc;
    dec_next = dec;
    err_next = err;
    bl = '0;
    popf = 1'b0;
    pushf = 1'b0;
    pk = 1'b0;
    clr = 1'b0;
    used = 1'b0;
    stop = 1'b0;
    key = 1'b0;
    o = 8'h00;
    ook = 1'b0;
    u = 16'h0000;
    rb = q_item.raw;
    lb = q_item.low;
    if (err != jst_pkg::ERR_NONE) begin
      bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_ERROR, 8'h00, 6'(depth), err, 1'b0));
      clr = q_item.eot;
    end else if (q_item.eot) begin
      // close an open number, then check for a complete top-level value
      clr = 1'b1;
      if (st_next == jst_pkg::ST_NUMBER) begin
        if (lkind_next != jst_pkg::LK_VALID) begin
          err_next = jst_pkg::ERR_NUMBER;
          bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_ERROR, 8'h00, 6'(depth_next),
                                                   err_next, 1'b0));
          stop = 1'b1;
        end else begin
          bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_NUM_END, 8'h00, 6'(depth_next),
                                                   err_next, dec_next));
          st_next = jst_pkg::ST_EATWS;
          ret_next = jst_pkg::ST_FINISH;
        end
      end
      if (!stop) begin
        if (depth_next == '0 && ret_next == jst_pkg::ST_FINISH &&
            (st_next == jst_pkg::ST_EATWS || st_next == jst_pkg::ST_CEOL)) begin
          bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_DONE, 8'h00, 6'(depth_next),
                                                   err_next, 1'b0));
        end else begin
          err_next = jst_pkg::ERR_EOF;
          bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_ERROR, 8'h00, 6'(depth_next),
                                                   err_next, 1'b0));
        end
      end
    end else begin
      // non-consuming moves chain within the cycle until the byte is used
      for (int g = 0; g < jst_pkg::STEPS; g++) begin
        if (!used && !stop) begin
          unique case (st_next) inside
            jst_pkg::ST_EATWS: begin
              if (q_item.ws) begin
                used = 1'b1;
              end else if (rb == "/") begin
                st_next = jst_pkg::ST_CSTART;
                used = 1'b1;
              end else begin
                st_next = ret_next;
              end
            end
            jst_pkg::ST_CSTART: begin
              used = 1'b1;
              if (rb == "*") begin
                st_next = jst_pkg::ST_COMMENT;
              end else if (rb == "/") begin
                st_next = jst_pkg::ST_CEOL;
              end else begin
                err_next = jst_pkg::ERR_COMMENT;
                stop = 1'b1;
              end
            end
            jst_pkg::ST_COMMENT: begin
              used = 1'b1;
              if (rb == "*") begin
                st_next = jst_pkg::ST_CEND;
              end
            end
            jst_pkg::ST_CEND: begin
              used = 1'b1;
              if (rb == "/") begin
                st_next = jst_pkg::ST_EATWS;
              end else if (rb != "*") begin
                st_next = jst_pkg::ST_COMMENT;
              end
            end
            jst_pkg::ST_CEOL: begin
              used = 1'b1;
              if (rb == 8'h0a) begin
                st_next = jst_pkg::ST_EATWS;
              end
            end
            jst_pkg::ST_START: begin
              used = 1'b1;
              if (rb == "{") begin
                kind_next = 1'b1;
                st_next = jst_pkg::ST_EATWS;
                ret_next = jst_pkg::ST_FSTART;
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_OBJ_BEGIN, 8'h00,
                                                         6'(depth_next), err_next, 1'b0));
              end else if (rb == "[") begin
                kind_next = 1'b0;
                st_next = jst_pkg::ST_EATWS;
                ret_next = jst_pkg::ST_ARRAY;
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_ARR_BEGIN, 8'h00,
                                                         6'(depth_next), err_next, 1'b0));
              end else if (lb == "n") begin
                st_next = jst_pkg::ST_NULL;
                lpos_next = 3'd1;
              end else if (rb == "\"" || rb == "'") begin
                quote_next = rb;
                st_next = jst_pkg::ST_STRING;
              end else if (lb == "t" || lb == "f") begin
                st_next = jst_pkg::ST_BOOL;
                lkind_next = (lb == "f") ? 2'd1 : 2'd0;
                lpos_next = 3'd1;
              end else if (q_item.digit || rb == "-") begin
                st_next = jst_pkg::ST_NUMBER;
                dec_next = 1'b0;
                lkind_next = q_item.digit ? jst_pkg::LK_VALID : jst_pkg::LK_NONE;
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_NUM_BYTE, rb,
                                                         6'(depth_next), err_next, 1'b0));
              end else begin
                err_next = jst_pkg::ERR_UNEXP;
                stop = 1'b1;
              end
            end
            jst_pkg::ST_FINISH: begin
              if (depth_next == '0) begin
                err_next = jst_pkg::ERR_UNEXP;
                stop = 1'b1;
              end else begin
                // the parent always waits in the add state
                depth_next = depth_next - DW'(1);
                kind_next = stk[0];
                st_next = jst_pkg::ST_ADD;
                popf = 1'b1;
              end
            end
            jst_pkg::ST_NULL: begin
              used = 1'b1;
              if (lpos_next < 3'd4 && lb == jst_pkg::null_ch(lpos_next[1:0])) begin
                if (lpos_next == 3'd3) begin
                  bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_NULL, 8'h00,
                                                           6'(depth_next), err_next, 1'b0));
                  st_next = jst_pkg::ST_EATWS;
                  ret_next = jst_pkg::ST_FINISH;
                end else begin
                  lpos_next = lpos_next + 3'd1;
                end
              end else begin
                err_next = jst_pkg::ERR_NULL;
                stop = 1'b1;
              end
            end
            jst_pkg::ST_BOOL: begin
              used = 1'b1;
              if ((lkind_next != 2'd0) ?
                  (lpos_next < 3'd5 && lb == jst_pkg::false_ch(lpos_next)) :
                  (lpos_next < 3'd4 && lb == jst_pkg::true_ch(lpos_next[1:0]))) begin
                if (lpos_next == ((lkind_next != 2'd0) ? 3'd4 : 3'd3)) begin
                  bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                         (lkind_next != 2'd0) ? jst_pkg::EV_FALSE : jst_pkg::EV_TRUE,
                         8'h00, 6'(depth_next), err_next, 1'b0));
                  st_next = jst_pkg::ST_EATWS;
                  ret_next = jst_pkg::ST_FINISH;
                end else begin
                  lpos_next = lpos_next + 3'd1;
                end
              end else begin
                err_next = jst_pkg::ERR_BOOL;
                stop = 1'b1;
              end
            end
            jst_pkg::ST_STRING, jst_pkg::ST_FIELD: begin
              used = 1'b1;
              key = (st_next == jst_pkg::ST_FIELD);
              if (rb == quote_next) begin
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                       key ? jst_pkg::EV_KEY_END : jst_pkg::EV_STR_END,
                       8'h00, 6'(depth_next), err_next, 1'b0));
                ret_next = key ? jst_pkg::ST_FEND : jst_pkg::ST_FINISH;
                st_next = jst_pkg::ST_EATWS;
              end else if (rb == "\\") begin
                ret_next = st_next;
                st_next = jst_pkg::ST_ESC;
              end else begin
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                       key ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE,
                       rb, 6'(depth_next), err_next, 1'b0));
              end
            end
            jst_pkg::ST_ESC: begin
              used = 1'b1;
              key = (ret_next == jst_pkg::ST_FIELD);
              if (rb == "u") begin
                uacc_next = 16'h0000;
                lpos_next = 3'd0;
                st_next = jst_pkg::ST_UNI;
              end else begin
                ook = 1'b1;
                case (rb)
                  "\"", "\\", "/": o = rb;
                  "b": o = 8'd8;
                  "f": o = 8'd12;
                  "n": o = 8'd10;
                  "r": o = 8'd13;
                  "t": o = 8'd9;
                  default: ook = 1'b0;
                endcase
                if (ook) begin
                  bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                         key ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE,
                         o, 6'(depth_next), err_next, 1'b0));
                  st_next = ret_next;
                end else begin
                  err_next = jst_pkg::ERR_STRING;
                  stop = 1'b1;
                end
              end
            end
            jst_pkg::ST_UNI: begin
              key = (ret_next == jst_pkg::ST_FIELD);
              if (!q_item.hexok) begin
                err_next = jst_pkg::ERR_STRING;
                stop = 1'b1;
              end else begin
                used = 1'b1;
                uacc_next = {uacc_next[11:0], q_item.hexv};
                lpos_next = lpos_next + 3'd1;
                if (lpos_next >= 3'd4) begin
                  // utf-8 encode the code unit into one to three bytes
                  u = uacc_next;
                  if (u < 16'h0080) begin
                    bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                           key ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE,
                           u[7:0], 6'(depth_next), err_next, 1'b0));
                  end else if (u < 16'h0800) begin
                    bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                           key ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE,
                           8'hc0 | {3'b000, u[10:6]}, 6'(depth_next), err_next, 1'b0));
                    bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                           key ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE,
                           8'h80 | {2'b00, u[5:0]}, 6'(depth_next), err_next, 1'b0));
                  end else begin
                    bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                           key ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE,
                           8'he0 | {4'b0000, u[15:12]}, 6'(depth_next), err_next, 1'b0));
                    bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                           key ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE,
                           8'h80 | {2'b00, u[11:6]}, 6'(depth_next), err_next, 1'b0));
                    bl = jst_pkg::push_ev(bl, jst_pkg::mkres(
                           key ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE,
                           8'h80 | {2'b00, u[5:0]}, 6'(depth_next), err_next, 1'b0));
                  end
                  st_next = ret_next;
                end
              end
            end
            jst_pkg::ST_NUMBER: begin
              if (q_item.numb) begin
                used = 1'b1;
                if (rb == "." || rb == "e" || rb == "E") begin
                  dec_next = 1'b1;
                end
                if (lkind_next == 2'd0) begin
                  lkind_next = q_item.digit ? 2'd1 : ((rb == ".") ? 2'd3 : 2'd2);
                end else if (lkind_next == 2'd3) begin
                  lkind_next = q_item.digit ? 2'd1 : 2'd2;
                end
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_NUM_BYTE, rb,
                                                         6'(depth_next), err_next, 1'b0));
              end else if (lkind_next != jst_pkg::LK_VALID) begin
                err_next = jst_pkg::ERR_NUMBER;
                stop = 1'b1;
              end else begin
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_NUM_END, 8'h00,
                                                         6'(depth_next), err_next, dec_next));
                st_next = jst_pkg::ST_EATWS;
                ret_next = jst_pkg::ST_FINISH;
              end
            end
            jst_pkg::ST_ARRAY, jst_pkg::ST_OVALUE: begin
              if (st_next == jst_pkg::ST_ARRAY && rb == "]") begin
                used = 1'b1;
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_ARR_END, 8'h00,
                                                         6'(depth_next), err_next, 1'b0));
                st_next = jst_pkg::ST_EATWS;
                ret_next = jst_pkg::ST_FINISH;
              end else if (CW'(depth_next) + CW'(1) >= lim) begin
                err_next = jst_pkg::ERR_DEPTH;
                stop = 1'b1;
              end else begin
                // open a child level; parent kind moves onto the stack
                pushf = 1'b1;
                pk = kind_next;
                depth_next = depth_next + DW'(1);
                st_next = jst_pkg::ST_EATWS;
                ret_next = jst_pkg::ST_START;
                kind_next = 1'b0;
              end
            end
            jst_pkg::ST_ADD: begin
              ret_next = kind_next ? jst_pkg::ST_OSEP : jst_pkg::ST_ASEP;
              st_next = jst_pkg::ST_EATWS;
            end
            jst_pkg::ST_ASEP: begin
              used = 1'b1;
              if (rb == "]") begin
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_ARR_END, 8'h00,
                                                         6'(depth_next), err_next, 1'b0));
                st_next = jst_pkg::ST_EATWS;
                ret_next = jst_pkg::ST_FINISH;
              end else if (rb == ",") begin
                ret_next = jst_pkg::ST_ARRAY;
                st_next = jst_pkg::ST_EATWS;
              end else begin
                err_next = jst_pkg::ERR_ARR_SEP;
                stop = 1'b1;
              end
            end
            jst_pkg::ST_FSTART: begin
              used = 1'b1;
              if (rb == "}") begin
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_OBJ_END, 8'h00,
                                                         6'(depth_next), err_next, 1'b0));
                st_next = jst_pkg::ST_EATWS;
                ret_next = jst_pkg::ST_FINISH;
              end else if (rb == "\"" || rb == "'") begin
                quote_next = rb;
                st_next = jst_pkg::ST_FIELD;
              end else begin
                err_next = jst_pkg::ERR_KEY;
                stop = 1'b1;
              end
            end
            jst_pkg::ST_FEND: begin
              used = 1'b1;
              if (rb == ":") begin
                ret_next = jst_pkg::ST_OVALUE;
                st_next = jst_pkg::ST_EATWS;
              end else begin
                err_next = jst_pkg::ERR_KEY_SEP;
                stop = 1'b1;
              end
            end
            jst_pkg::ST_OSEP: begin
              used = 1'b1;
              if (rb == "}") begin
                bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_OBJ_END, 8'h00,
                                                         6'(depth_next), err_next, 1'b0));
                st_next = jst_pkg::ST_EATWS;
                ret_next = jst_pkg::ST_FINISH;
              end else if (rb == ",") begin
                ret_next = jst_pkg::ST_FSTART;
                st_next = jst_pkg::ST_EATWS;
              end else begin
                err_next = jst_pkg::ERR_VAL_SEP;
                stop = 1'b1;
              end
            end
            default: begin
              err_next = jst_pkg::ERR_UNEXP;
              stop = 1'b1;
            end
          endcase
          if (stop) begin
            bl = jst_pkg::push_ev(bl, jst_pkg::mkres(jst_pkg::EV_ERROR, 8'h00,
                                                     6'(depth_next), err_next, 1'b0));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= jst_pkg::ST_EATWS;
      ret <= jst_pkg::ST_START;
      kind <= 1'b0;
      depth <= '0;
      quote <= 8'h00;
      lpos <= 3'd0;
      lkind <= 2'd0;
      uacc <= 16'h0000;
      dec <= 1'b0;
      err <= jst_pkg::ERR_NONE;
      rem <= 3'd0;
    end else begin
      if (take) begin
        if (clr) begin
          st <= jst_pkg::ST_EATWS;
          ret <= jst_pkg::ST_START;
          kind <= 1'b0;
          depth <= '0;
          quote <= 8'h00;
          lpos <= 3'd0;
          lkind <= 2'd0;
          uacc <= 16'h0000;
          dec <= 1'b0;
          err <= jst_pkg::ERR_NONE;
        end else begin
          st <= st_next;
          ret <= ret_next;
          kind <= kind_next;
          depth <= depth_next;
          quote <= quote_next;
          lpos <= lpos_next;
          lkind <= lkind_next;
          uacc <= uacc_next;
          dec <= dec_next;
          err <= err_next;
        end
        rem <= bl.n;
      end else if (fire) begin
        rem <= rem - 3'd1;
      end
    end
  end

  // parent kinds; entry 0 is the level just below the current one
  always_ff @(posedge clk) begin
    if (take && !clr && pushf) begin
      stk <= {stk[MAX_NESTING-2:0], pk};
    end else if (take && !clr && popf) begin
      stk <= {1'b0, stk[MAX_NESTING-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bq <= bl.e;
    end else if (fire) begin
      bq <= {bq[3], bq[3:1]};
    end
  end

  assign token_out.valid = (rem != 3'd0);
  assign token_out.event_res = bq[0].ev;
  assign token_out.data_byte = bq[0].data;
  assign token_out.nesting_level = bq[0].lvl;
  assign token_out.error_code = bq[0].err;
  assign token_out.number_is_decimal = bq[0].dec;
  assign token_out.last_of_run = (rem == 3'd1);

  `JST_ASSERT_NEXT(a_end_clears, take && q_item.eot, depth == '0 && err == jst_pkg::ERR_NONE)
  `JST_ASSERT_NEXT(a_err_sticky, err != jst_pkg::ERR_NONE && !(take && q_item.eot),
                   err == $past(err))
  `JST_ASSERT_HOLD(a_no_push_pop, !(take && pushf && popf))
  `JST_ASSERT_HOLD(a_rem_range, rem <= 3'd4)

endmodule

FILE: src/json_stream_tokenizer.sv
// top level of the json stream tokenizer
// Streaming JSON tokenizer: one text byte per input word, token words out. A byte is taken
// every cycle while the queue has room: the front classifies it, a two-entry queue holds it, and
// the back resolves the whole per-level state chain for that byte combinationally (whitespace
// and comment skipping, strings and keys with escapes and \u to utf-8, case-blind null/true/false,
// numbers with a decimal flag, object and array nesting up to MAX_NESTING levels). Results leave
// one word per cycle from the back's result register while the sink is ready, so a byte that
// causes more than one result (at most 4, e.g. a three-byte utf-8 escape or a number closed by a
// bracket) holds the back until its last result leaves; all other bytes sustain one per cycle
// while the sink is ready. The first error is latched and repeated for each later byte until end
// of text, which also resets the tokenizer. No clearing pass is needed after reset. Register 0
// (nesting_limit, byte address 0) must be written only between texts; the block does not enforce this.
module json_stream_tokenizer #(
  parameter int MAX_NESTING = jst_pkg::MAX_NESTING_DEF
) (
  input  logic        clk,
  input  logic        rst,
  jst_in_if.sink      byte_in,
  jst_out_if.source   token_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0]       limit;
  logic             f_valid, f_ready;
  jst_pkg::q_item_t f_item;
  logic             q_valid, q_pop;
  jst_pkg::q_item_t q_item;

  // apb register file: only nesting_limit, at word 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {26'd0, limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= jst_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      limit <= pwdata[5:0];
    end
  end

  // byte classification
  jst_front u_front (
    .byte_in    (byte_in),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  // decouples the input from result backpressure
  jst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_item  (f_item),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .rd_pop   (q_pop)
  );

  // token engine and result register
  jst_back #(
    .MAX_NESTING (MAX_NESTING)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .limit     (limit),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .token_out (token_out)
  );

endmodule
